// ===== src/bvalu_pkg.sv =====
package bvalu_pkg;

   localparam int DataWidth  = 64;
   localparam int WidthBits  = 7;
   localparam int CmdBits    = 5;
   localparam int MaxWidth   = 64;
   localparam int HalfWidth  = DataWidth / 2;
   localparam int ShiftBits  = $clog2(DataWidth);
   localparam int DivSteps   = DataWidth;

   localparam logic [CmdBits-1:0] CmdAdd  = 5'd0;
   localparam logic [CmdBits-1:0] CmdSub  = 5'd1;
   localparam logic [CmdBits-1:0] CmdMul  = 5'd2;
   localparam logic [CmdBits-1:0] CmdUdiv = 5'd3;
   localparam logic [CmdBits-1:0] CmdSdiv = 5'd4;
   localparam logic [CmdBits-1:0] CmdUrem = 5'd5;
   localparam logic [CmdBits-1:0] CmdSrem = 5'd6;
   localparam logic [CmdBits-1:0] CmdShl  = 5'd7;
   localparam logic [CmdBits-1:0] CmdLshr = 5'd8;
   localparam logic [CmdBits-1:0] CmdAshr = 5'd9;
   localparam logic [CmdBits-1:0] CmdAnd  = 5'd10;
   localparam logic [CmdBits-1:0] CmdOr   = 5'd11;
   localparam logic [CmdBits-1:0] CmdXor  = 5'd12;
   localparam logic [CmdBits-1:0] CmdSlt  = 5'd13;
   localparam logic [CmdBits-1:0] CmdSgt  = 5'd14;
   localparam logic [CmdBits-1:0] CmdSle  = 5'd15;
   localparam logic [CmdBits-1:0] CmdSge  = 5'd16;
   localparam logic [CmdBits-1:0] CmdUlt  = 5'd17;
   localparam logic [CmdBits-1:0] CmdUgt  = 5'd18;
   localparam logic [CmdBits-1:0] CmdUle  = 5'd19;
   localparam logic [CmdBits-1:0] CmdUge  = 5'd20;

   typedef struct packed {
      logic [CmdBits-1:0]   cmd;
      logic [DataWidth-1:0] left_operand;
      logic [DataWidth-1:0] right_operand;
      logic [WidthBits-1:0] operand_width;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] value_out;
      logic                 compare_true;
   } rsp_type;

   typedef struct packed {
      logic [CmdBits-1:0]   cmd;
      logic [DataWidth-1:0] mask;
      logic                 neg_a;
      logic                 neg_b;
      logic                 b_zero;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] simple_val;
      logic                 flag;
   } ctl_type;

endpackage

// ===== src/bitvector_alu_smtlib_top.sv =====
// Bit-vector ALU with SMT-LIB semantics.
// Request channel: drive req_data (cmd, operands, operand width) and raise
// start; the word is taken at a rising edge where start is high and busy is
// low. busy is high during reset and only in the cycle after it, so a new
// word may enter on every cycle.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_data
// (value_out, compare_true). The receiver cannot stall; every response must
// be taken in the cycle it is shown.
// Every command takes the same path from the accepting edge to the edge that
// takes the response: one input register, one prepare stage (masking,
// magnitudes, shifts, compares, partial products), 64 restoring divide
// stages of one quotient bit each, and the output register.
// The 64-stage divider is pipelined; throughput is one word per cycle once busy is low.
// Responses leave in request order.
// Reset is synchronous and clears all valid bits; words in flight are lost.
module bitvector_alu_smtlib_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bvalu_pkg::req_type req_data,
   output logic               rsp_strobe,
   output bvalu_pkg::rsp_type rsp_data
);
   import bvalu_pkg::*;

   // ---------------- input register ----------------
   logic                 busy_ff;
   logic                 s1_valid_ff;
   logic [CmdBits-1:0]   s1_cmd_ff;
   logic [DataWidth-1:0] s1_a_ff, s1_b_ff, s1_mask_ff;
   logic [ShiftBits-1:0] s1_wm1_ff;   // width minus one
   logic [WidthBits-1:0] s1_w_ff;

   logic [WidthBits-1:0] w_in;
   logic [DataWidth-1:0] mask_in;

   always_comb begin
      w_in = req_data.operand_width;
      if (w_in == '0) begin
         w_in = WidthBits'(1);
      end
      if (w_in > WidthBits'(MaxWidth)) begin
         w_in = WidthBits'(MaxWidth);
      end
      if (w_in >= WidthBits'(DataWidth)) begin
         mask_in = '1;
      end else begin
         mask_in = (DataWidth'(1) << w_in) - DataWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= start && !busy_ff;
      end
      s1_cmd_ff  <= req_data.cmd;
      s1_a_ff    <= req_data.left_operand & mask_in;
      s1_b_ff    <= req_data.right_operand & mask_in;
      s1_mask_ff <= mask_in;
      s1_w_ff    <= w_in;
      s1_wm1_ff  <= ShiftBits'(w_in - WidthBits'(1));
   end

   assign busy = busy_ff;

   // ---------------- prepare stage ----------------
   logic                 neg_a, neg_b, is_signed_div, signed_cmp, lt, gt, too_far;
   logic [DataWidth-1:0] sbit, mag_a, mag_b, cmp_l, cmp_r, shr_val;
   ctl_type              ctl_p0_in;

   always_comb begin
      neg_a         = s1_a_ff[s1_wm1_ff];
      neg_b         = s1_b_ff[s1_wm1_ff];
      sbit          = DataWidth'(1) << s1_wm1_ff;
      is_signed_div = (s1_cmd_ff == CmdSdiv) || (s1_cmd_ff == CmdSrem);
      mag_a = (is_signed_div && neg_a) ? ((~s1_a_ff + DataWidth'(1)) & s1_mask_ff) : s1_a_ff;
      mag_b = (is_signed_div && neg_b) ? ((~s1_b_ff + DataWidth'(1)) & s1_mask_ff) : s1_b_ff;

      // Flip the sign bit to turn a signed order into an unsigned one.
      signed_cmp = (s1_cmd_ff >= CmdSlt) && (s1_cmd_ff <= CmdSge);
      cmp_l = signed_cmp ? (s1_a_ff ^ sbit) : s1_a_ff;
      cmp_r = signed_cmp ? (s1_b_ff ^ sbit) : s1_b_ff;
      lt    = cmp_l < cmp_r;
      gt    = cmp_l > cmp_r;

      too_far = s1_b_ff >= DataWidth'(s1_w_ff);
      shr_val = s1_a_ff >> s1_b_ff[ShiftBits-1:0];

      ctl_p0_in.cmd    = s1_cmd_ff;
      ctl_p0_in.mask   = s1_mask_ff;
      ctl_p0_in.neg_a  = neg_a;
      ctl_p0_in.neg_b  = neg_b;
      ctl_p0_in.b_zero = (s1_b_ff == '0);
      ctl_p0_in.a      = s1_a_ff;
      ctl_p0_in.flag   = 1'b0;
      ctl_p0_in.simple_val = '0;

      case (s1_cmd_ff) inside
         CmdAdd: ctl_p0_in.simple_val = s1_a_ff + s1_b_ff;
         CmdSub: ctl_p0_in.simple_val = s1_a_ff - s1_b_ff;
         CmdShl: ctl_p0_in.simple_val =
            too_far ? '0 : (s1_a_ff << s1_b_ff[ShiftBits-1:0]);
         CmdLshr: ctl_p0_in.simple_val = too_far ? '0 : shr_val;
         CmdAshr: begin
            if (too_far) begin
               ctl_p0_in.simple_val = neg_a ? s1_mask_ff : '0;
            end else if (neg_a) begin
               ctl_p0_in.simple_val = shr_val |
                  (s1_mask_ff & ~(s1_mask_ff >> s1_b_ff[ShiftBits-1:0]));
            end else begin
               ctl_p0_in.simple_val = shr_val;
            end
         end
         CmdAnd: ctl_p0_in.simple_val = s1_a_ff & s1_b_ff;
         CmdOr:  ctl_p0_in.simple_val = s1_a_ff | s1_b_ff;
         CmdXor: ctl_p0_in.simple_val = s1_a_ff ^ s1_b_ff;
         CmdSlt, CmdUlt: ctl_p0_in.flag = lt;
         CmdSgt, CmdUgt: ctl_p0_in.flag = gt;
         CmdSle, CmdUle: ctl_p0_in.flag = !gt;
         CmdSge, CmdUge: ctl_p0_in.flag = !lt;
         default: ctl_p0_in.simple_val = '0;
      endcase
   end

   // ---------------- divide pipeline ----------------
   logic                 valid_ff [0:DivSteps];
   ctl_type              ctl_ff   [0:DivSteps];
   logic [DataWidth-1:0] rem_ff   [0:DivSteps];
   logic [DataWidth-1:0] nq_ff    [0:DivSteps];   // numerator shifts out, quotient in
   logic [DataWidth-1:0] den_ff   [0:DivSteps];

   // Partial products of the low 64 bits of a*b, kept beside the first stage.
   logic [DataWidth-1:0] mul_ll_ff;
   logic [HalfWidth-1:0] mul_lh_ff, mul_hl_ff;
   logic [DataWidth-1:0] mul_ll_in, mul_lh_full, mul_hl_full;

   always_comb begin
      mul_ll_in   = s1_a_ff[HalfWidth-1:0] * s1_b_ff[HalfWidth-1:0];
      mul_lh_full = s1_a_ff[HalfWidth-1:0] * s1_b_ff[DataWidth-1:HalfWidth];
      mul_hl_full = s1_a_ff[DataWidth-1:HalfWidth] * s1_b_ff[HalfWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= s1_valid_ff;
      end
      ctl_ff[0]  <= ctl_p0_in;
      rem_ff[0]  <= '0;
      nq_ff[0]   <= mag_a;
      den_ff[0]  <= mag_b;
      mul_ll_ff  <= mul_ll_in;
      mul_lh_ff  <= mul_lh_full[HalfWidth-1:0];
      mul_hl_ff  <= mul_hl_full[HalfWidth-1:0];
   end

   logic [HalfWidth-1:0] mul_cross;
   logic [DataWidth-1:0] mul_val;
   assign mul_cross = mul_lh_ff + mul_hl_ff;
   assign mul_val   = mul_ll_ff + {mul_cross, {HalfWidth{1'b0}}};

   for (genvar p = 0; p < DivSteps; p++) begin : g_div
      logic [DataWidth:0]   trial;
      logic [DataWidth:0]   diff;
      logic                 ge;
      logic [DataWidth-1:0] rem_in, nq_in;
      ctl_type              ctl_in;

      always_comb begin
         trial  = {rem_ff[p], nq_ff[p][DataWidth-1]};
         diff   = trial - {1'b0, den_ff[p]};
         ge     = trial >= {1'b0, den_ff[p]};
         rem_in = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
         nq_in  = {nq_ff[p][DataWidth-2:0], ge};
         ctl_in = ctl_ff[p];
         if (p == 0 && ctl_ff[p].cmd == CmdMul) begin
            ctl_in.simple_val = mul_val;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[p+1] <= 1'b0;
         end else begin
            valid_ff[p+1] <= valid_ff[p];
         end
         ctl_ff[p+1] <= ctl_in;
         rem_ff[p+1] <= rem_in;
         nq_ff[p+1]  <= nq_in;
         den_ff[p+1] <= den_ff[p];
      end
   end

   // ---------------- result select and output register ----------------
   ctl_type              ctl_last;
   logic [DataWidth-1:0] quo, rem, val;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff;

   always_comb begin
      ctl_last = ctl_ff[DivSteps];
      quo      = nq_ff[DivSteps];
      rem      = rem_ff[DivSteps];
      case (ctl_last.cmd)
         CmdUdiv: val = ctl_last.b_zero ? ctl_last.mask : quo;
         CmdSdiv: begin
            if (ctl_last.b_zero) begin
               val = ctl_last.neg_a ? DataWidth'(1) : ctl_last.mask;
            end else if (ctl_last.neg_a != ctl_last.neg_b) begin
               val = ~quo + DataWidth'(1);
            end else begin
               val = quo;
            end
         end
         CmdUrem: val = ctl_last.b_zero ? ctl_last.a : rem;
         CmdSrem: begin
            if (ctl_last.b_zero) begin
               val = ctl_last.a;
            end else begin
               val = ctl_last.neg_a ? (~rem + DataWidth'(1)) : rem;
            end
         end
         default: val = ctl_last.simple_val;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[DivSteps];
      end
      rsp_ff.value_out    <= val & ctl_last.mask;
      rsp_ff.compare_true <= ctl_last.flag;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // A response always comes from a word in the last divide stage.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(valid_ff[DivSteps]))
      else $error("response without a word in the last stage");

   // Comparisons report only through the flag.
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.compare_true) |-> (rsp_data.value_out == '0))
      else $error("comparison with nonzero value");

   // Every value stays within the word's width.
   a_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.value_out & ~$past(ctl_ff[DivSteps].mask)) == '0))
      else $error("value exceeds operand width");

   // The block takes a word on every cycle once out of reset.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside reset recovery");
`endif

endmodule

// ===== verif/bitvector_alu_smtlib_top_test.sv =====
`timescale 1ns / 100ps

module bitvector_alu_smtlib_top_test;
   import bvalu_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Responses still owed by the ALU, oldest first.
   rsp_type owed_results[$];
   int      mismatch_count;
   int      stray_count;

   bitvector_alu_smtlib_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Compute the SMT-LIB bit-vector result for one word.
   function automatic rsp_type alu_result(req_type w);
      rsp_type          r;
      int unsigned      wd;
      logic [63:0]      m, a, b, v, q, rm, ma, mb, sbit, l, rr;
      logic             na, nb;
      begin
         wd = w.operand_width;
         if (wd == 0) wd = 1;
         if (wd > MaxWidth) wd = MaxWidth;
         m = (wd >= 64) ? '1 : ((64'd1 << wd) - 64'd1);
         a = w.left_operand & m;
         b = w.right_operand & m;
         sbit = 64'd1 << (wd - 1);
         na = (a & sbit) != 0;
         nb = (b & sbit) != 0;
         ma = na ? ((~a + 64'd1) & m) : a;
         mb = nb ? ((~b + 64'd1) & m) : b;
         v = '0;
         r.compare_true = 1'b0;
         case (w.cmd)
            CmdAdd: v = a + b;
            CmdSub: v = a - b;
            CmdMul: v = a * b;
            CmdUdiv: v = (b == 0) ? m : a / b;
            CmdSdiv: begin
               if (b == 0) v = na ? 64'd1 : m;
               else begin
                  q = ma / mb;
                  v = (na != nb) ? (~q + 64'd1) : q;
               end
            end
            CmdUrem: v = (b == 0) ? a : a % b;
            CmdSrem: begin
               if (b == 0) v = a;
               else begin
                  rm = ma % mb;
                  v = na ? (~rm + 64'd1) : rm;
               end
            end
            CmdShl:  v = (b >= wd) ? '0 : (a << b);
            CmdLshr: v = (b >= wd) ? '0 : (a >> b);
            CmdAshr: begin
               if (b >= wd) v = na ? m : '0;
               else begin
                  v = a >> b;
                  if (na) v = v | (m & ~(m >> b));
               end
            end
            CmdAnd: v = a & b;
            CmdOr:  v = a | b;
            CmdXor: v = a ^ b;
            CmdSlt, CmdSgt, CmdSle, CmdSge, CmdUlt, CmdUgt, CmdUle, CmdUge: begin
               l = a;
               rr = b;
               // Flip the sign bit to turn a signed order into an unsigned one.
               if (w.cmd <= CmdSge) begin
                  l = l ^ sbit;
                  rr = rr ^ sbit;
               end
               case (w.cmd)
                  CmdSlt, CmdUlt: r.compare_true = l < rr;
                  CmdSgt, CmdUgt: r.compare_true = l > rr;
                  CmdSle, CmdUle: r.compare_true = l <= rr;
                  default:        r.compare_true = l >= rr;
               endcase
            end
            default: v = '0;
         endcase
         r.value_out = v & m;
         return r;
      end
   endfunction

   // Check each response against the oldest owed one.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (owed_results.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= 10)
               $display("unexpected response %h", rsp_data);
         end else begin
            e = owed_results.pop_front();
            if (e.value_out !== rsp_data.value_out ||
                e.compare_true !== rsp_data.compare_true) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value %h flag %b, got value %h flag %b",
                           e.value_out, e.compare_true, rsp_data.value_out,
                           rsp_data.compare_true);
            end
         end
      end
   end

   // Mostly short gaps, a few long ones, and stretches with none.
   function automatic int gap_length();
      int n;
      begin
         n = $urandom_range(0, 99);
         if (n < 55) n = 0;
         else if (n < 92) n = $urandom_range(1, 3);
         else n = $urandom_range(5, 30);
         return n;
      end
   endfunction

   // Drive one word and hold it until the ALU takes it.
   task automatic send_word(input req_type w, input bit gaps);
      int n;
      begin
         start <= 1'b1;
         req_data <= w;
         @(posedge clock);
         while (busy) @(posedge clock);
         owed_results.push_back(alu_result(w));
         @(negedge clock);
         n = 0;
         if (gaps && $urandom_range(0, 3) == 0) n = gap_length();
         // Drop start only when time passes before the next word.
         if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_word(logic [4:0] c, logic [63:0] a,
                                         logic [63:0] b, logic [6:0] wd);
      req_type w;
      begin
         w.cmd = c;
         w.left_operand = a;
         w.right_operand = b;
         w.operand_width = wd;
         return w;
      end
   endfunction

   // Walk every command over extremes, zero divisors, overflow, wide shifts.
   task automatic test_directed();
      begin
         send_word(make_word(CmdAdd, '1, '1, 7'd64), 0);
         send_word(make_word(CmdSub, '0, 64'd1, 7'd64), 0);
         send_word(make_word(CmdMul, '1, '1, 7'd64), 0);
         send_word(make_word(CmdUdiv, 64'd55, '0, 7'd8), 0);
         send_word(make_word(CmdSdiv, 64'h80, '0, 7'd8), 0);
         send_word(make_word(CmdSdiv, 64'h7f, '0, 7'd8), 0);
         send_word(make_word(CmdSdiv, 64'h8000_0000_0000_0000, '1, 7'd64), 0);
         send_word(make_word(CmdSrem, 64'h80, 64'hff, 7'd8), 0);
         send_word(make_word(CmdSdiv, 64'hf9, 64'd2, 7'd8), 0);
         send_word(make_word(CmdUrem, 64'd77, '0, 7'd16), 0);
         send_word(make_word(CmdSrem, 64'hfff9, '0, 7'd16), 0);
         send_word(make_word(CmdSrem, 64'hf9, 64'd2, 7'd8), 0);
         send_word(make_word(CmdShl, '1, 64'd64, 7'd64), 0);
         send_word(make_word(CmdLshr, '1, 64'd8, 7'd8), 0);
         send_word(make_word(CmdAshr, 64'h80, 64'd200, 7'd8), 0);
         send_word(make_word(CmdAshr, 64'h80, 64'd3, 7'd8), 0);
         send_word(make_word(CmdAnd, '1, 64'h1234, 7'd0), 0);
         send_word(make_word(CmdOr, '1, '0, 7'd127), 0);
         send_word(make_word(CmdXor, '1, 64'h5555, 7'd1), 0);
         send_word(make_word(CmdSlt, 64'h80, 64'h7f, 7'd8), 0);
         send_word(make_word(CmdSgt, 64'h80, 64'h7f, 7'd8), 0);
         send_word(make_word(CmdSle, '1, '1, 7'd64), 0);
         send_word(make_word(CmdSge, '0, '1, 7'd64), 0);
         send_word(make_word(CmdUlt, 64'h80, 64'h7f, 7'd8), 0);
         send_word(make_word(CmdUgt, '1, '0, 7'd64), 0);
         send_word(make_word(CmdUle, 64'd3, 64'd3, 7'd2), 0);
         send_word(make_word(CmdUge, '0, '1, 7'd33), 0);
         send_word(make_word(5'd31, '1, '1, 7'd64), 0);
      end
   endtask

   // Random words: mostly legal widths, small ones favored, with bit extremes.
   task automatic test_random(input int count);
      req_type w;
      int      k;
      begin
         for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            w.cmd = (k < 4) ? 5'($urandom_range(21, 31)) : 5'($urandom_range(0, 20));
            k = $urandom_range(0, 99);
            if (k < 40) w.operand_width = 7'($urandom_range(1, 16));
            else if (k < 90) w.operand_width = 7'($urandom_range(17, 64));
            else w.operand_width = 7'($urandom);
            w.left_operand = rand64();
            w.right_operand = rand64();
            case ($urandom_range(0, 7))
               0: w.right_operand = '0;
               1: w.right_operand = 64'($urandom_range(0, 70));
               2: w.left_operand = '1;
               3: w.right_operand = '1;
               4: w.right_operand = w.right_operand >> $urandom_range(0, 63);
               default: ;
            endcase
            send_word(w, 1);
         end
         start <= 1'b0;
      end
   endtask

   initial begin
      mismatch_count = 0;
      stray_count = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(850);
      while (owed_results.size() != 0) @(posedge clock);
      // Let the pipeline drain so a stray response still shows up.
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && stray_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bvalu_pkg.sv
src/bitvector_alu_smtlib_top.sv
verif/bitvector_alu_smtlib_top_test.sv
